@@ hdl/cdw_pkg.sv @@
// shared types and constants for the concentric disk warp pipeline
// no dependencies; used by every module of the block by scoped names
`timescale 1ns / 1ps
package cdw_pkg;

  // Q30 values run up to and including one, so they need 31 bits
  localparam int Q_BITS = 31;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [29:0] PI_QUARTER_Q30 = 30'd843314857;

  // horner series: lane 0 is sine, lane 1 is cosine
  localparam int TERMS = 6;
  localparam int LANES = 2;
  localparam logic [7:0] SERIES_DEN [LANES][TERMS] = '{
    '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6},
    '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2}
  };
  // floor(2^32 / den), used for divide-by-constant with one correction step
  localparam logic [31:0] SERIES_RECIP [LANES][TERMS] = '{
    '{32'((64'd1 << 32) / 64'd156), 32'((64'd1 << 32) / 64'd110),
      32'((64'd1 << 32) / 64'd72), 32'((64'd1 << 32) / 64'd42),
      32'((64'd1 << 32) / 64'd20), 32'((64'd1 << 32) / 64'd6)},
    '{32'((64'd1 << 32) / 64'd132), 32'((64'd1 << 32) / 64'd90),
      32'((64'd1 << 32) / 64'd56), 32'((64'd1 << 32) / 64'd30),
      32'((64'd1 << 32) / 64'd12), 32'((64'd1 << 32) / 64'd2)}
  };

  typedef enum logic {
    REG_WARP_MODE        = 1'b0,
    REG_CENTER_THRESHOLD = 1'b1
  } reg_idx_t;

  localparam logic [15:0] THRESHOLD_RESET = 16'd7;

  // per-item control that travels beside the data
  typedef struct packed {
    logic first;   // |px| > |py|
    logic neg_x;
    logic neg_y;
    logic center;  // point collapses to the origin
  } flags_t;

endpackage

@@ hdl/cdw_div.sv @@
// pipelined restoring divider: q = floor(small * 2^30 / large), one quotient bit per stage
// depends on cdw_pkg
`timescale 1ns / 1ps
module cdw_div #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_vld,
  input  logic [SAMPLE_BITS:0]     in_large,
  input  logic [SAMPLE_BITS:0]     in_small,
  input  cdw_pkg::flags_t          in_fl,
  output logic                     out_vld,
  output logic [cdw_pkg::Q_BITS-1:0] out_q,
  output logic [SAMPLE_BITS:0]     out_large,
  output cdw_pkg::flags_t          out_fl
);

  localparam int NS = cdw_pkg::Q_BITS;
  localparam int RW = SAMPLE_BITS + 2;

  logic                   vld_r   [NS];
  logic [RW-1:0]          rem_r   [NS];
  logic [NS-1:0]          q_r     [NS];
  logic [SAMPLE_BITS:0]   large_r [NS];
  cdw_pkg::flags_t        fl_r    [NS];

  for (genvar i = 0; i < NS; i++) begin : g_stage
    logic                 vld_in;
    logic [RW-1:0]        rem_in;
    logic [NS-1:0]        q_in;
    logic [SAMPLE_BITS:0] large_in;
    cdw_pkg::flags_t      fl_in;
    logic                 take;
    logic [RW-1:0]        rem_nxt;

    if (i == 0) begin : g_head
      assign vld_in   = in_vld;
      assign rem_in   = RW'(in_small);
      assign q_in     = '0;
      assign large_in = in_large;
      assign fl_in    = in_fl;
    end else begin : g_body
      assign vld_in   = vld_r[i-1];
      assign rem_in   = rem_r[i-1];
      assign q_in     = q_r[i-1];
      assign large_in = large_r[i-1];
      assign fl_in    = fl_r[i-1];
    end

    assign take    = rem_in >= RW'(large_in);
    assign rem_nxt = take ? rem_in - RW'(large_in) : rem_in;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]   <= {rem_nxt[RW-2:0], 1'b0};
        q_r[i]     <= {q_in[NS-2:0], take};
        large_r[i] <= large_in;
        fl_r[i]    <= fl_in;
      end
    end
  end

  assign out_vld   = vld_r[NS-1];
  assign out_q     = q_r[NS-1];
  assign out_large = large_r[NS-1];
  assign out_fl    = fl_r[NS-1];

endmodule

@@ hdl/cdw_trig.sv @@
// angle, sine/cosine horner series and radius scaling, 22 register stages
// depends on cdw_pkg
`timescale 1ns / 1ps
module cdw_trig #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_vld,
  input  logic [cdw_pkg::Q_BITS-1:0] in_q,
  input  logic [SAMPLE_BITS:0]       in_large,
  input  cdw_pkg::flags_t            in_fl,
  output logic                       out_vld,
  output logic [cdw_pkg::Q_BITS-1:0] out_xm,
  output logic [cdw_pkg::Q_BITS-1:0] out_ym,
  output cdw_pkg::flags_t            out_fl
);

  localparam int NT = cdw_pkg::TERMS;
  localparam int NL = cdw_pkg::LANES;

  typedef struct packed {
    logic [29:0]     s2;
    logic [29:0]     ang;
    logic [30:0]     r30;
    cdw_pkg::flags_t fl;
  } side_t;

  // angle stage
  logic [60:0] ang_prod;
  logic [30:0] r30;
  logic        vld0_r;
  logic [29:0] ang0_r;
  logic [30:0] r30_0_r;
  cdw_pkg::flags_t fl0_r;

  assign ang_prod = 61'(in_q) * 61'(cdw_pkg::PI_QUARTER_Q30);

  if (SAMPLE_BITS <= 30) begin : g_r30_up
    assign r30 = 31'(in_large) << (30 - SAMPLE_BITS);
  end else begin : g_r30_down
    assign r30 = in_large[SAMPLE_BITS -: 31];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else if (en) begin
      vld0_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang0_r  <= ang_prod[59:30];
      r30_0_r <= r30;
      fl0_r   <= in_fl;
    end
  end

  // angle squared
  logic [59:0] sq_prod;
  logic        vld1_r;
  side_t       sd1_r;

  assign sq_prod = 60'(ang0_r) * 60'(ang0_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else if (en) begin
      vld1_r <= vld0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd1_r <= '{s2: sq_prod[59:30], ang: ang0_r, r30: r30_0_r, fl: fl0_r};
    end
  end

  // horner steps: multiply, reciprocal multiply, correct and subtract
  logic        vla_r [NT];
  logic        vlb_r [NT];
  logic        vlc_r [NT];
  side_t       sda_r [NT];
  side_t       sdb_r [NT];
  side_t       sdc_r [NT];
  logic [60:0] prod_r [NT][NL];
  logic [30:0] y_r    [NT][NL];
  logic [62:0] est_r  [NT][NL];
  logic [30:0] t_r    [NT][NL];

  for (genvar j = 0; j < NT; j++) begin : g_term
    logic  vld_in;
    side_t sd_in;

    if (j == 0) begin : g_first
      assign vld_in = vld1_r;
      assign sd_in  = sd1_r;
    end else begin : g_next
      assign vld_in = vlc_r[j-1];
      assign sd_in  = sdc_r[j-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vla_r[j] <= 1'b0;
        vlb_r[j] <= 1'b0;
        vlc_r[j] <= 1'b0;
      end else if (en) begin
        vla_r[j] <= vld_in;
        vlb_r[j] <= vla_r[j];
        vlc_r[j] <= vlb_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sda_r[j] <= sd_in;
        sdb_r[j] <= sda_r[j];
        sdc_r[j] <= sdb_r[j];
      end
    end

    for (genvar l = 0; l < NL; l++) begin : g_lane
      logic [30:0] t_in;
      logic [30:0] y;
      logic [30:0] e;
      logic [39:0] ek;
      logic [39:0] rem;
      logic [30:0] qd;

      if (j == 0) begin : g_one
        assign t_in = cdw_pkg::ONE_Q30;
      end else begin : g_prev
        assign t_in = t_r[j-1][l];
      end

      assign y   = prod_r[j][l][60:30];
      assign e   = est_r[j][l][62:32];
      assign ek  = 40'(e) * 40'(cdw_pkg::SERIES_DEN[l][j]);
      assign rem = 40'(y_r[j][l]) - ek;
      // the reciprocal estimate is at most one low
      assign qd  = (rem >= 40'(cdw_pkg::SERIES_DEN[l][j])) ? e + 31'd1 : e;

      always_ff @(posedge clk) begin
        if (en) begin
          prod_r[j][l] <= 61'(sd_in.s2) * 61'(t_in);
          y_r[j][l]    <= y;
          est_r[j][l]  <= 63'(y) * 63'(cdw_pkg::SERIES_RECIP[l][j]);
          t_r[j][l]    <= cdw_pkg::ONE_Q30 - qd;
        end
      end
    end
  end

  // sine = angle * series
  logic [60:0] sn_prod;
  logic        vld2_r;
  logic [30:0] sn2_r;
  logic [30:0] cs2_r;
  side_t       sd2_r;

  assign sn_prod = 61'(sdc_r[NT-1].ang) * 61'(t_r[NT-1][0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else if (en) begin
      vld2_r <= vlc_r[NT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sn2_r <= sn_prod[60:30];
      cs2_r <= t_r[NT-1][1];
      sd2_r <= sdc_r[NT-1];
    end
  end

  // scale by radius and place on the axes; center points give zero
  logic [61:0] cp_prod;
  logic [61:0] sp_prod;
  logic [30:0] xm_nxt;
  logic [30:0] ym_nxt;
  logic        vld3_r;
  logic [30:0] xm_r;
  logic [30:0] ym_r;
  cdw_pkg::flags_t fl3_r;

  assign cp_prod = 62'(sd2_r.r30) * 62'(cs2_r);
  assign sp_prod = 62'(sd2_r.r30) * 62'(sn2_r);

  always_comb begin
    if (sd2_r.fl.center) begin
      xm_nxt = '0;
      ym_nxt = '0;
    end else if (sd2_r.fl.first) begin
      xm_nxt = cp_prod[60:30];
      ym_nxt = sp_prod[60:30];
    end else begin
      xm_nxt = sp_prod[60:30];
      ym_nxt = cp_prod[60:30];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld3_r <= 1'b0;
    end else if (en) begin
      vld3_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xm_r  <= xm_nxt;
      ym_r  <= ym_nxt;
      fl3_r <= sd2_r.fl;
    end
  end

  assign out_vld = vld3_r;
  assign out_xm  = xm_r;
  assign out_ym  = ym_r;
  assign out_fl  = fl3_r;

endmodule

@@ hdl/cdw_zq.sv @@
// hemisphere height by pipelined integer square root, then rounding and saturation
// depends on cdw_pkg; 34 register stages
`timescale 1ns / 1ps
module cdw_zq #(
  parameter int OUT_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       warp_mode,
  input  logic                       in_vld,
  input  logic [cdw_pkg::Q_BITS-1:0] in_xm,
  input  logic [cdw_pkg::Q_BITS-1:0] in_ym,
  input  cdw_pkg::flags_t            in_fl,
  output logic                       out_vld,
  output logic [OUT_BITS-1:0]        out_x,
  output logic [OUT_BITS-1:0]        out_y,
  output logic [OUT_BITS-2:0]        out_z
);

  localparam int NS  = cdw_pkg::Q_BITS;
  localparam int SH  = 31 - OUT_BITS;
  localparam int SHP = (SH > 0) ? SH : 1;
  localparam int SHL = (SH < 0) ? -SH : 0;
  localparam logic [32:0] LIM = 33'd1 << (OUT_BITS - 1);
  localparam logic [61:0] FULL = 62'd1 << 60;

  typedef struct packed {
    logic [30:0]     xm;
    logic [30:0]     ym;
    cdw_pkg::flags_t fl;
  } side_t;

  // q30 to output fraction bits, round half up
  function automatic logic [32:0] quant(input logic [30:0] m);
    logic [32:0] w;
    w = 33'(m);
    if (SH > 0) begin
      quant = (w + (33'd1 << (SHP - 1))) >> SHP;
    end else begin
      quant = w << SHL;
    end
  endfunction

  function automatic logic [OUT_BITS-1:0] enc(input logic [30:0] m, input logic neg);
    logic [32:0] v;
    logic [32:0] s;
    v = quant(m);
    if (neg) begin
      s = (v > LIM) ? LIM : v;
      s = 33'd0 - s;
    end else begin
      s = (v > LIM - 33'd1) ? LIM - 33'd1 : v;
    end
    enc = s[OUT_BITS-1:0];
  endfunction

  // squares
  logic        vld0_r;
  logic [61:0] xsq_r;
  logic [61:0] ysq_r;
  side_t       sd0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else if (en) begin
      vld0_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xsq_r <= 62'(in_xm) * 62'(in_xm);
      ysq_r <= 62'(in_ym) * 62'(in_ym);
      sd0_r <= '{xm: in_xm, ym: in_ym, fl: in_fl};
    end
  end

  // radicand 1 - r^2, floored at zero
  logic [61:0] sum;
  logic        vld1_r;
  logic [61:0] rad1_r;
  side_t       sd1_r;

  assign sum = xsq_r + ysq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else if (en) begin
      vld1_r <= vld0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad1_r <= (sum >= FULL) ? '0 : FULL - sum;
      sd1_r  <= sd0_r;
    end
  end

  // square root, one result bit per stage
  logic        vs_r  [NS];
  logic [61:0] v_r   [NS];
  logic [61:0] res_r [NS];
  side_t       ss_r  [NS];

  for (genvar k = 0; k < NS; k++) begin : g_root
    localparam logic [61:0] BIT = 62'd1 << (60 - 2 * k);
    logic        vld_in;
    logic [61:0] v_in;
    logic [61:0] res_in;
    side_t       sd_in;
    logic [61:0] trial;
    logic        fit;

    if (k == 0) begin : g_head
      assign vld_in = vld1_r;
      assign v_in   = rad1_r;
      assign res_in = '0;
      assign sd_in  = sd1_r;
    end else begin : g_body
      assign vld_in = vs_r[k-1];
      assign v_in   = v_r[k-1];
      assign res_in = res_r[k-1];
      assign sd_in  = ss_r[k-1];
    end

    assign trial = res_in + BIT;
    assign fit   = v_in >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vs_r[k] <= 1'b0;
      end else if (en) begin
        vs_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        v_r[k]   <= fit ? v_in - trial : v_in;
        res_r[k] <= fit ? (res_in >> 1) + BIT : res_in >> 1;
        ss_r[k]  <= sd_in;
      end
    end
  end

  // final rounding and saturation; z is zero when warp_mode is off
  logic [32:0]         zq;
  logic [OUT_BITS-2:0] z_nxt;
  logic                vf_r;
  logic [OUT_BITS-1:0] x_r;
  logic [OUT_BITS-1:0] y_r;
  logic [OUT_BITS-2:0] z_r;

  assign zq = quant(res_r[NS-1][30:0]);

  always_comb begin
    if (!warp_mode) begin
      z_nxt = '0;
    end else if (zq > LIM - 33'd1) begin
      z_nxt = (OUT_BITS - 1)'(LIM - 33'd1);
    end else begin
      z_nxt = zq[OUT_BITS-2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else if (en) begin
      vf_r <= vs_r[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= enc(ss_r[NS-1].xm, ss_r[NS-1].fl.neg_x);
      y_r <= enc(ss_r[NS-1].ym, ss_r[NS-1].fl.neg_y);
      z_r <= z_nxt;
    end
  end

  assign out_vld = vf_r;
  assign out_x   = x_r;
  assign out_y   = y_r;
  assign out_z   = z_r;

endmodule

@@ hdl/concentric_disk_warp.sv @@
// concentric disk warp; stages from input beat to out_valid (1 front, 31 divide, 22 trig,
// 34 root/round, 1 output buffer); one beat per cycle sustained while the output buffer
// is not full, as the divider and square root are fully pipelined, one bit per stage each
// reset (synchronous, rst_n low) clears all valid bits and the output buffer,
// and sets warp_mode to 0 and center_threshold to 7
// depends on cdw_pkg, cdw_div, cdw_trig, cdw_zq
`timescale 1ns / 1ps
module concentric_disk_warp #(
  parameter int SAMPLE_BITS = 16,
  parameter int OUT_BITS    = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] in_sample_u,
  input  logic [SAMPLE_BITS-1:0] in_sample_v,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [OUT_BITS-1:0]    out_x,
  output logic [OUT_BITS-1:0]    out_y,
  output logic [OUT_BITS-2:0]    out_z,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [15:0]            cfg_data
);

  // ---------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------
  logic        warp_mode_r;
  logic [15:0] center_threshold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warp_mode_r        <= 1'b0;
      center_threshold_r <= cdw_pkg::THRESHOLD_RESET;
    end else if (cfg_we) begin
      unique case (cdw_pkg::reg_idx_t'(cfg_index))
        cdw_pkg::REG_WARP_MODE:        warp_mode_r        <= cfg_data[0];
        cdw_pkg::REG_CENTER_THRESHOLD: center_threshold_r <= cfg_data;
        default:                       warp_mode_r        <= warp_mode_r;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // pipeline enable: the whole pipe moves together, and only halts
  // when the last stage holds a result and the output buffer is full.
  // depends on registers only, so out_ready never reaches in_ready
  // ---------------------------------------------------------------
  logic       en;
  logic       zq_vld;
  logic [1:0] cnt_r;

  assign en       = !(zq_vld && (cnt_r == 2'd2));
  assign in_ready = en;

  // ---------------------------------------------------------------
  // front stage: p = 2s - 1, magnitudes, octant and center test
  // ---------------------------------------------------------------
  logic signed [SAMPLE_BITS+1:0] px;
  logic signed [SAMPLE_BITS+1:0] py;
  logic [SAMPLE_BITS+1:0]        px_neg;
  logic [SAMPLE_BITS+1:0]        py_neg;
  logic [SAMPLE_BITS:0]          ax;
  logic [SAMPLE_BITS:0]          ay;
  cdw_pkg::flags_t               fl_nxt;

  assign px     = $signed({1'b0, in_sample_u, 1'b0}) - $signed({2'b01, {SAMPLE_BITS{1'b0}}});
  assign py     = $signed({1'b0, in_sample_v, 1'b0}) - $signed({2'b01, {SAMPLE_BITS{1'b0}}});
  assign px_neg = -px;
  assign py_neg = -py;
  assign ax     = px[SAMPLE_BITS+1] ? px_neg[SAMPLE_BITS:0] : px[SAMPLE_BITS:0];
  assign ay     = py[SAMPLE_BITS+1] ? py_neg[SAMPLE_BITS:0] : py[SAMPLE_BITS:0];

  // exact center always collapses, even with a zero threshold;
  // on a magnitude tie the y form is used
  assign fl_nxt.first  = ax > ay;
  assign fl_nxt.neg_x  = px[SAMPLE_BITS+1];
  assign fl_nxt.neg_y  = py[SAMPLE_BITS+1];
  assign fl_nxt.center = ((33'(ax) < 33'(center_threshold_r)) &&
                          (33'(ay) < 33'(center_threshold_r))) ||
                         ((ax == '0) && (ay == '0));

  logic                 fvld_r;
  logic [SAMPLE_BITS:0] large_r;
  logic [SAMPLE_BITS:0] small_r;
  cdw_pkg::flags_t      ffl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fvld_r <= 1'b0;
    end else if (en) begin
      fvld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      large_r <= fl_nxt.first ? ax : ay;
      small_r <= fl_nxt.first ? ay : ax;
      ffl_r   <= fl_nxt;
    end
  end

  // ---------------------------------------------------------------
  // ratio small/large in q30
  // ---------------------------------------------------------------
  logic                       dv_vld;
  logic [cdw_pkg::Q_BITS-1:0] dv_q;
  logic [SAMPLE_BITS:0]       dv_large;
  cdw_pkg::flags_t            dv_fl;

  cdw_div #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_vld    (fvld_r),
    .in_large  (large_r),
    .in_small  (small_r),
    .in_fl     (ffl_r),
    .out_vld   (dv_vld),
    .out_q     (dv_q),
    .out_large (dv_large),
    .out_fl    (dv_fl)
  );

  // ---------------------------------------------------------------
  // angle, sin/cos series, scale by radius
  // ---------------------------------------------------------------
  logic                       tg_vld;
  logic [cdw_pkg::Q_BITS-1:0] tg_xm;
  logic [cdw_pkg::Q_BITS-1:0] tg_ym;
  cdw_pkg::flags_t            tg_fl;

  cdw_trig #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_trig (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (dv_vld),
    .in_q     (dv_q),
    .in_large (dv_large),
    .in_fl    (dv_fl),
    .out_vld  (tg_vld),
    .out_xm   (tg_xm),
    .out_ym   (tg_ym),
    .out_fl   (tg_fl)
  );

  // ---------------------------------------------------------------
  // hemisphere height and output formatting
  // ---------------------------------------------------------------
  logic [OUT_BITS-1:0] zq_x;
  logic [OUT_BITS-1:0] zq_y;
  logic [OUT_BITS-2:0] zq_z;

  cdw_zq #(
    .OUT_BITS (OUT_BITS)
  ) u_zq (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .warp_mode (warp_mode_r),
    .in_vld    (tg_vld),
    .in_xm     (tg_xm),
    .in_ym     (tg_ym),
    .in_fl     (tg_fl),
    .out_vld   (zq_vld),
    .out_x     (zq_x),
    .out_y     (zq_y),
    .out_z     (zq_z)
  );

  // ---------------------------------------------------------------
  // two-entry output buffer: keeps the pipe moving while a beat waits
  // ---------------------------------------------------------------
  logic [OUT_BITS-1:0] bx_r [2];
  logic [OUT_BITS-1:0] by_r [2];
  logic [OUT_BITS-2:0] bz_r [2];
  logic                wp_r;
  logic                rp_r;
  logic [1:0]          cnt_nxt;
  logic                push;
  logic                pop;

  assign push = en && zq_vld;
  assign pop  = out_valid && out_ready;

  always_comb begin
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      bx_r[wp_r] <= zq_x;
      by_r[wp_r] <= zq_y;
      bz_r[wp_r] <= zq_z;
    end
  end

  assign out_valid = cnt_r != 2'd0;
  assign out_x     = bx_r[rp_r];
  assign out_y     = by_r[rp_r];
  assign out_z     = bz_r[rp_r];

endmodule
